// File: design/ftd_pkg.sv
// Shared types and constants of the dual fractional tick divider.
// No dependencies; every other file of the block refers to it by scoped names.
package ftd_pkg;

  // Field widths
  localparam int SAMPLE_W   = 11;
  localparam int FIRE_A_W   = 17;
  localparam int FIRE_B_W   = 2;
  localparam int ACC_W      = 16;
  localparam int TGT_W      = 16;
  localparam int CLK_W      = 23;
  localparam int QR_W       = 7;
  localparam int RR_W       = 16;
  localparam int P_W        = RR_W + SAMPLE_W;
  localparam int QN_W       = QR_W + SAMPLE_W;
  localparam int Q_W        = SAMPLE_W;
  localparam int FIRE_W     = QN_W;
  localparam int RECIP_W    = 28;
  localparam int RECIP_SH   = 43;
  localparam int DIV_STEPS  = CLK_W;
  localparam int DIV_CW     = $clog2(DIV_STEPS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Timing constants
  localparam logic [CLK_W-1:0]   CNT_A_CLOCK = 23'd4233600;
  localparam logic [RR_W-1:0]    TICK_RATE   = 16'd44100;
  // ceil(2^43 / 44100): exact quotient for any dividend below 2^27
  localparam logic [RECIP_W-1:0] TICK_RECIP  = 28'd199457892;
  localparam logic [RR_W-1:0]    RATE_PAL    = 16'd50;
  localparam logic [RR_W-1:0]    RATE_NTSC   = 16'd60;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CNT_A_TARGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CNT_A_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_MODE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CNT_B_ENABLE = 2'd3;

  // Operation and channel codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam logic SEL_A    = 1'b0;
  localparam logic SEL_B    = 1'b1;

  typedef struct packed {
    logic                op;
    logic                counter_select;
    logic [SAMPLE_W-1:0] sample_count;
  } in_item_t;

  typedef struct packed {
    logic [FIRE_A_W-1:0] cnt_a_fires;
    logic [FIRE_B_W-1:0] cnt_b_fires;
  } out_item_t;

  // Rate split as rate = qr * 44100 + rr
  typedef struct packed {
    logic [QR_W-1:0] qr;
    logic [RR_W-1:0] rr;
  } rate_split_t;

  // Stage load enables shared by both lanes
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld_out;
    logic commit;
  } lane_ctl_t;

endpackage

// File: design/dual_fractional_tick_divider_top.sv
// Dual fractional tick divider, top level.
// One item per cycle sustained while neither out_stall nor a rate derivation holds the flow.
// A nonzero write of counter A's target holds !cfg_ready, and in_stall from the write cycle
// on, while the rate is derived: 23 restoring-divider steps, then the whole part, then
// the remainder. Reset (rst_n low, synchronous): registers, rate and both accumulators go
// to zero, pipeline empties.
module dual_fractional_tick_divider_top #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ftd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ftd_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ftd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ftd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Largest count the input field can carry; a cap above it never bites.
  localparam int SAMPLE_MAX = (1 << ftd_pkg::SAMPLE_W) - 1;
  localparam logic [ftd_pkg::SAMPLE_W-1:0] N_CAP =
    ftd_pkg::SAMPLE_W'((MAX_SAMPLES > SAMPLE_MAX) ? SAMPLE_MAX : MAX_SAMPLES);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ftd_pkg::TGT_W-1:0] tgt_r;
  logic                      en_a_r, pal_r, en_b_r;
  logic                      cfg_wr, tgt_wr;
  logic                      rate_busy;
  ftd_pkg::rate_split_t      rate_a, rate_b;

  assign cfg_ready = !rate_busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign tgt_wr    = cfg_wr && (cfg_index == ftd_pkg::REG_CNT_A_TARGET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= '0;
      en_a_r <= 1'b0;
      pal_r  <= 1'b0;
      en_b_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index)
        ftd_pkg::REG_CNT_A_TARGET: tgt_r  <= cfg_data;
        ftd_pkg::REG_CNT_A_ENABLE: en_a_r <= cfg_data[0];
        ftd_pkg::REG_PAL_MODE:     pal_r  <= cfg_data[0];
        ftd_pkg::REG_CNT_B_ENABLE: en_b_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Counter A rate: derived once per target write, held as quotient and
  // remainder of the tick rate. A target of zero gives a zero rate at once.
  ftd_rate_ctl u_rate_ctl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (tgt_wr),
    .target (cfg_data),
    .busy   (rate_busy),
    .rate   (rate_a)
  );

  // Counter B's rate is always below the tick rate: no whole part.
  assign rate_b.qr = '0;
  assign rate_b.rr = pal_r ? ftd_pkg::RATE_PAL : ftd_pkg::RATE_NTSC;

  // ---------------------------------------------------------------------------
  // Pipeline control: input register, three lane stages, result register.
  // Each stage advances when it is empty or its successor advances, so
  // bubbles close up and the input keeps taking items while a result waits, until stages fill.
  // ---------------------------------------------------------------------------
  logic              v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic              adv0, adv1, adv2, adv3, adv_out;
  logic              in_xfer;
  ftd_pkg::in_item_t in_r;
  ftd_pkg::lane_ctl_t lane_ctl;

  assign adv_out = !out_valid_r || !out_stall;
  assign adv3    = !v3_r || adv_out;
  assign adv2    = !v2_r || adv3;
  assign adv1    = !v1_r || adv2;
  assign adv0    = !v0_r || adv1;

  // Hold off items while the rate is being derived, including the write cycle.
  assign in_stall = !adv0 || rate_busy || tgt_wr;
  assign in_xfer  = in_valid && !in_stall;

  assign lane_ctl.ld1    = adv1;
  assign lane_ctl.ld2    = adv2;
  assign lane_ctl.ld3    = adv3;
  assign lane_ctl.ld_out = adv_out;
  // advance the accumulators only for a real item leaving stage 3
  assign lane_ctl.commit = adv_out && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv0)    v0_r        <= in_xfer;
      if (adv1)    v1_r        <= v0_r;
      if (adv2)    v2_r        <= v1_r;
      if (adv3)    v3_r        <= v2_r;
      if (adv_out) out_valid_r <= v3_r;
    end
  end

  // Input register: saturate the sample count on the way in.
  always_ff @(posedge clk) begin
    if (adv0) begin
      in_r.op             <= in_data.op;
      in_r.counter_select <= in_data.counter_select;
      if (32'(in_data.sample_count) > 32'(MAX_SAMPLES)) begin
        in_r.sample_count <= N_CAP;
      end else begin
        in_r.sample_count <= in_data.sample_count;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes
  // ---------------------------------------------------------------------------
  logic is_tick, is_clear;
  logic act_a, act_b, clr_a, clr_b;
  logic [ftd_pkg::FIRE_W-1:0] fires_a, fires_b;

  assign is_tick  = (in_r.op == ftd_pkg::OP_TICK);
  assign is_clear = (in_r.op == ftd_pkg::OP_CLEAR);
  assign act_a    = is_tick && en_a_r;
  assign act_b    = is_tick && en_b_r;
  assign clr_a    = is_clear && (in_r.counter_select == ftd_pkg::SEL_A);
  assign clr_b    = is_clear && (in_r.counter_select == ftd_pkg::SEL_B);

  ftd_lane u_lane_a (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .act   (act_a),
    .clr   (clr_a),
    .n     (in_r.sample_count),
    .rate  (rate_a),
    .fires (fires_a)
  );

  ftd_lane u_lane_b (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lane_ctl),
    .act   (act_b),
    .clr   (clr_b),
    .n     (in_r.sample_count),
    .rate  (rate_b),
    .fires (fires_b)
  );

  // Result register lives in the lanes; drop the bits above the field widths.
  assign out_valid            = out_valid_r;
  assign out_data.cnt_a_fires = fires_a[ftd_pkg::FIRE_A_W-1:0];
  assign out_data.cnt_b_fires = fires_b[ftd_pkg::FIRE_B_W-1:0];

endmodule

// File: design/ftd_div.sv
// Restoring divider, one quotient bit per cycle, used for the counter A rate.
// Depends on ftd_pkg for widths.
module ftd_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [ftd_pkg::CLK_W-1:0]        dividend,
  input  logic [ftd_pkg::RR_W-1:0]         divisor,
  output logic                             done,
  output logic [ftd_pkg::CLK_W-1:0]        quo
);

  logic [ftd_pkg::DIV_CW-1:0] cnt_r;
  logic                       done_r;
  logic [ftd_pkg::CLK_W-1:0]  quo_r, quo_nxt;
  logic [ftd_pkg::RR_W-1:0]   rem_r, rem_nxt;
  logic [ftd_pkg::RR_W-1:0]   dsr_r;
  logic [ftd_pkg::RR_W:0]     trial;
  logic                       ge;

  always_comb begin
    trial   = {rem_r, quo_r[ftd_pkg::CLK_W-1]};
    ge      = trial >= {1'b0, dsr_r};
    rem_nxt = ge ? ftd_pkg::RR_W'(trial - {1'b0, dsr_r}) : trial[ftd_pkg::RR_W-1:0];
    quo_nxt = {quo_r[ftd_pkg::CLK_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == ftd_pkg::DIV_CW'(1));
      if (start) begin
        cnt_r <= ftd_pkg::DIV_CW'(ftd_pkg::DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - ftd_pkg::DIV_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: design/ftd_rate_ctl.sv
// Derives counter A's rate from its target and splits it by the tick rate.
// Depends on ftd_pkg and ftd_div.
module ftd_rate_ctl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ftd_pkg::TGT_W-1:0]  target,
  output logic                       busy,
  output ftd_pkg::rate_split_t       rate
);

  localparam int RP_W = ftd_pkg::CLK_W + ftd_pkg::RECIP_W;

  typedef enum logic [1:0] {ST_IDLE, ST_RATE, ST_SPLIT} state_t;

  state_t                     state_r, state_nxt;
  ftd_pkg::rate_split_t       rate_r, rate_nxt;
  logic                       div_start;
  logic                       div_done;
  logic [ftd_pkg::CLK_W-1:0]  div_quo;
  logic [RP_W-1:0]            recip_prod;
  logic [ftd_pkg::CLK_W-1:0]  whole;
  logic [ftd_pkg::CLK_W-1:0]  frac;

  ftd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ftd_pkg::CNT_A_CLOCK),
    .divisor  (target),
    .done     (div_done),
    .quo      (div_quo)
  );

  always_comb begin
    state_nxt  = state_r;
    rate_nxt   = rate_r;
    div_start  = 1'b0;
    // whole part of rate / 44100 by reciprocal multiply, exact below 2^27
    recip_prod = RP_W'(div_quo) * RP_W'(ftd_pkg::TICK_RECIP);
    whole      = ftd_pkg::CLK_W'(rate_r.qr) * ftd_pkg::CLK_W'(ftd_pkg::TICK_RATE);
    frac       = div_quo - whole;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (target == '0) begin
            rate_nxt = '0;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_RATE;
          end
        end
      end
      ST_RATE: begin
        // rate found and held by the divider: take its whole tick periods
        if (div_done) begin
          rate_nxt.qr = recip_prod[ftd_pkg::RECIP_SH +: ftd_pkg::QR_W];
          state_nxt   = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        rate_nxt.rr = frac[ftd_pkg::RR_W-1:0];
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rate_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rate_r  <= rate_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);
  assign rate = rate_r;

endmodule

// File: design/ftd_lane.sv
// One counter channel: product, reciprocal split, remainder fold into the accumulator.
// Depends on ftd_pkg; load enables come from the top level.
module ftd_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ftd_pkg::lane_ctl_t            ctl,
  input  logic                          act,
  input  logic                          clr,
  input  logic [ftd_pkg::SAMPLE_W-1:0]  n,
  input  ftd_pkg::rate_split_t          rate,
  output logic [ftd_pkg::FIRE_W-1:0]    fires
);

  localparam int PROD_W = ftd_pkg::P_W + ftd_pkg::RECIP_W;

  // stage 1
  logic [ftd_pkg::P_W-1:0]    p1_r, p1_nxt;
  logic [ftd_pkg::QN_W-1:0]   qn1_r, qn1_nxt;
  logic                       clr1_r;
  // stage 2
  logic [PROD_W-1:0]          recip_prod;
  logic [ftd_pkg::Q_W-1:0]    q2_r, q2_nxt;
  logic [ftd_pkg::P_W-1:0]    p2_r;
  logic [ftd_pkg::QN_W-1:0]   qn2_r;
  logic                       clr2_r;
  // stage 3
  logic [ftd_pkg::P_W-1:0]    qm, diff;
  logic [ftd_pkg::RR_W-1:0]   r3_r, r3_nxt;
  logic [ftd_pkg::FIRE_W-1:0] f3_r, f3_nxt;
  logic                       clr3_r;
  // result stage
  logic [ftd_pkg::ACC_W:0]    sum;
  logic                       wrap;
  logic [ftd_pkg::ACC_W-1:0]  acc_r, acc_nxt;
  logic [ftd_pkg::FIRE_W-1:0] fires_r, fires_nxt;

  always_comb begin
    // a lane without act contributes nothing and, unless cleared, leaves its accumulator alone
    p1_nxt  = act ? ({{ftd_pkg::SAMPLE_W{1'b0}}, rate.rr} * {{ftd_pkg::RR_W{1'b0}}, n}) : '0;
    qn1_nxt = act ? ({{ftd_pkg::SAMPLE_W{1'b0}}, rate.qr} * {{ftd_pkg::QR_W{1'b0}}, n}) : '0;

    recip_prod = {{ftd_pkg::RECIP_W{1'b0}}, p1_r} * {{ftd_pkg::P_W{1'b0}}, ftd_pkg::TICK_RECIP};
    q2_nxt     = recip_prod[ftd_pkg::RECIP_SH +: ftd_pkg::Q_W];

    qm     = {{ftd_pkg::RR_W{1'b0}}, q2_r} * {{ftd_pkg::SAMPLE_W{1'b0}}, ftd_pkg::TICK_RATE};
    diff   = p2_r - qm;
    r3_nxt = diff[ftd_pkg::RR_W-1:0];
    f3_nxt = qn2_r + {{(ftd_pkg::QN_W - ftd_pkg::Q_W){1'b0}}, q2_r};

    sum       = {1'b0, acc_r} + {1'b0, r3_r};
    wrap      = sum >= {1'b0, ftd_pkg::TICK_RATE};
    fires_nxt = f3_r + {{(ftd_pkg::FIRE_W-1){1'b0}}, wrap};
    if (clr3_r) begin
      acc_nxt = '0;
    end else if (wrap) begin
      acc_nxt = ftd_pkg::ACC_W'(sum - {1'b0, ftd_pkg::TICK_RATE});
    end else begin
      acc_nxt = sum[ftd_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      p1_r   <= p1_nxt;
      qn1_r  <= qn1_nxt;
      clr1_r <= clr;
    end
    if (ctl.ld2) begin
      q2_r   <= q2_nxt;
      p2_r   <= p1_r;
      qn2_r  <= qn1_r;
      clr2_r <= clr1_r;
    end
    if (ctl.ld3) begin
      r3_r   <= r3_nxt;
      f3_r   <= f3_nxt;
      clr3_r <= clr2_r;
    end
    if (ctl.ld_out) begin
      fires_r <= fires_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.commit) begin
      acc_r <= acc_nxt;
    end
  end

  assign fires = fires_r;

endmodule

// File: design/ftd_checker.sv
// Port-level checks for the dual fractional tick divider, bound to its top level.
// Depends on ftd_pkg and dual_fractional_tick_divider_top.
module ftd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input ftd_pkg::out_item_t             out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [ftd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [ftd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = 5;

  logic       in_xfer, out_xfer;
  logic [2:0] inflight_r;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> inflight_r != 3'd0)
    else $error("result transfer without an outstanding item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= 3'(DEPTH))
    else $error("more items outstanding than pipeline stages");

  // a zero target gives counter A a zero rate and needs no derivation
  a_tgt_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == ftd_pkg::REG_CNT_A_TARGET && cfg_data != '0
    |=> in_stall)
    else $error("input taken while counter A rate is being derived");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

endmodule

bind dual_fractional_tick_divider_top ftd_checker u_ftd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);
